[hw/rtl/fdmcr_pkg.sv]
// Shared types and constants for the momentum/continuity residual stencil.
package fdmcr_pkg;

    localparam int unsigned NUM_CFG = 8;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS    = 3'd0,
        CFG_GRID_ROWS    = 3'd1,
        CFG_INV_TWO_DX   = 3'd2,
        CFG_INV_TWO_DY   = 3'd3,
        CFG_INV_DX_SQ    = 3'd4,
        CFG_INV_DY_SQ    = 3'd5,
        CFG_INV_DT       = 3'd6,
        CFG_INV_REYNOLDS = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pressure;
        logic signed [31:0] vel_x_prev;
        logic signed [31:0] vel_y_prev;
    } t_in_beat;

    typedef struct packed {
        logic        [11:0] cell_row;
        logic        [9:0]  cell_col;
        logic signed [31:0] resid_mom_x;
        logic signed [31:0] resid_mom_y;
        logic signed [31:0] resid_cont;
        logic        [31:0] norm_value;
        logic               is_norm;
    } t_out_beat;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] p;
    } t_flow;

    typedef struct packed {
        logic [31:0] inv_two_dx;
        logic [31:0] inv_two_dy;
        logic [31:0] inv_dx_sq;
        logic [31:0] inv_dy_sq;
        logic [31:0] inv_dt;
        logic [31:0] inv_reynolds;
    } t_coef;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [31:0] y;
        if (x > 72'sh0_0000_0000_7FFF_FFFF)
            y = 32'sh7FFF_FFFF;
        else if (x < -72'sh0_0000_0000_8000_0000)
            y = 32'sh8000_0000;
        else
            y = x[31:0];
        return y;
    endfunction

endpackage

[hw/rtl/fdmcr_stream_if.sv]
// Valid/ready stream interface for input and result beats.
interface fdmcr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/fdmcr_mul.sv]
// Registered signed-by-unsigned Q16.16 multiply with floor shift (result in the next cycle).
module fdmcr_mul (
    input  logic               i_clk,
    input  logic signed [35:0] i_a,
    input  logic        [31:0] i_k,
    output logic signed [51:0] o_p
);
    // Register two 36x16 partial products, then combine and floor.
    logic signed [52:0] r_hi;
    logic signed [52:0] r_lo;
    logic signed [52:0] n_sum;

    always_ff @(posedge i_clk) begin
        r_hi <= 53'(i_a * $signed({1'b0, i_k[31:16]}));
        r_lo <= 53'(i_a * $signed({1'b0, i_k[15:0]}));
    end

    // a*k/2^16 floored = a*kh + floor(a*kl/2^16)
    assign n_sum = r_hi + (r_lo >>> 16);
    assign o_p   = n_sum[51:0];
endmodule

[hw/rtl/fdmcr_sqrt.sv]
// Iterative 64-bit integer square root, one result bit per cycle.
module fdmcr_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] n_trial;

    // Restoring digit recurrence: bring down two bits, try (root<<2)|1.
    assign n_trial = {r_root, 2'b01};

    logic [35:0] r_part;
    logic [35:0] n_part;
    logic [63:0] r_src;
    assign n_part = {r_part[33:0], r_src[63:62]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_src  <= i_x;
                r_part <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_src <= {r_src[61:0], 2'b00};
                if (n_part >= 36'(n_trial)) begin
                    r_part <= n_part - 36'(n_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_part <= n_part;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[hw/rtl/fd_momentum_continuity_residual.sv]
// Top level: line-store stencil, residual datapath, square sum and norm.
// A cell result passes the sequencer states RD, D1, D2, D3, C1, C2, DIF, SUM, SQ
// and OUT after its input beat is accepted; the last point of the grid also waits
// in SQRT for the square root. A new input beat is taken only in IDLE, after the
// sequencer has stepped through memory reads, derivative, convection and diffusion
// products and the three square accumulations; a stalled result beat holds the input.
// Reset (synchronous, active low) clears counters, window, square sum and
// configuration to defaults; the line stores are undefined until written.
module fd_momentum_continuity_residual #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned MAX_ROWS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    fdmcr_stream_if.sink         s_in,
    fdmcr_stream_if.source       m_out
);
    localparam int unsigned CW = $clog2(MAX_COLS);
    localparam int unsigned RCW = $clog2(MAX_ROWS + 1);

    // ---------------- configuration ----------------
    logic [10:0] r_cols_raw;
    logic [12:0] r_rows_raw;
    fdmcr_pkg::t_coef r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_raw <= 11'd64;
            r_rows_raw <= 13'd64;
            r_coef <= '{inv_two_dx: 32'd32768, inv_two_dy: 32'd32768,
                        inv_dx_sq: 32'd65536, inv_dy_sq: 32'd65536,
                        inv_dt: 32'd65536, inv_reynolds: 32'd65536};
        end else if (i_cfg_we) begin
            case (fdmcr_pkg::t_cfg_idx'(i_cfg_idx))
                fdmcr_pkg::CFG_GRID_COLS:    r_cols_raw <= i_cfg_data[10:0];
                fdmcr_pkg::CFG_GRID_ROWS:    r_rows_raw <= i_cfg_data[12:0];
                fdmcr_pkg::CFG_INV_TWO_DX:   r_coef.inv_two_dx <= i_cfg_data;
                fdmcr_pkg::CFG_INV_TWO_DY:   r_coef.inv_two_dy <= i_cfg_data;
                fdmcr_pkg::CFG_INV_DX_SQ:    r_coef.inv_dx_sq <= i_cfg_data;
                fdmcr_pkg::CFG_INV_DY_SQ:    r_coef.inv_dy_sq <= i_cfg_data;
                fdmcr_pkg::CFG_INV_DT:       r_coef.inv_dt <= i_cfg_data;
                fdmcr_pkg::CFG_INV_REYNOLDS: r_coef.inv_reynolds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped sizes, kept 17 bits so parameters up to 2^17 - 1 fit.
    logic [16:0] n_cols, n_rows;
    always_comb begin
        n_cols = 17'(r_cols_raw);
        if (n_cols < 17'd3) n_cols = 17'd3;
        if (n_cols > 17'(MAX_COLS)) n_cols = 17'(MAX_COLS);
        n_rows = 17'(r_rows_raw);
        if (n_rows < 17'd3) n_rows = 17'd3;
        if (n_rows > 17'(MAX_ROWS)) n_rows = 17'(MAX_ROWS);
    end

    // ---------------- sequencer ----------------
    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_D1, ST_D2, ST_D3, ST_C1, ST_C2, ST_DIF, ST_SUM,
        ST_SQ, ST_SQRT, ST_OUT
    } t_state;
    t_state r_state;

    logic [CW-1:0]  r_col;
    logic [RCW-1:0] r_row;
    fdmcr_pkg::t_in_beat r_cur;
    fdmcr_pkg::t_in_beat r_win [3];
    fdmcr_pkg::t_in_beat r_lo;
    fdmcr_pkg::t_flow    r_up;
    logic r_emit, r_last;

    // Line stores: synchronous memories; center_mem is read in two states, upper_mem in one.
    fdmcr_pkg::t_flow    upper_mem  [MAX_COLS];
    fdmcr_pkg::t_in_beat center_mem [MAX_COLS];
    fdmcr_pkg::t_in_beat r_cmem_c, r_cmem_cm1;
    fdmcr_pkg::t_flow    r_umem_cm1;
    logic [CW-1:0] n_cm1;
    assign n_cm1 = r_col - CW'(1);

    logic in_fire;
    assign in_fire = s_in.valid & s_in.ready;
    assign s_in.ready = (r_state == ST_IDLE);

    // Memory reads happen in ST_IDLE on accept; second read next cycle.
    always_ff @(posedge i_clk) begin
        if (in_fire)
            r_cmem_c <= center_mem[r_col];
        if (r_state == ST_RD) begin
            r_cmem_cm1 <= center_mem[n_cm1];
            r_umem_cm1 <= upper_mem[n_cm1];
        end
        if (r_state == ST_D1) begin
            center_mem[r_col] <= r_cur;
            if (r_col != '0)
                upper_mem[n_cm1] <= '{u: r_win[1].vel_x, v: r_win[1].vel_y,
                                      p: r_win[1].pressure};
        end
    end

    // ---------------- multiplier sharing ----------------
    // Three multiplier lanes, shared across states, feed derivatives, time differences and diffusion terms per step.
    logic signed [35:0] n_a [3];
    logic        [31:0] n_k [3];
    logic signed [51:0] m_p [3];
    for (genvar g = 0; g < 3; g++) begin : g_mul
        fdmcr_mul u_mul (.i_clk(i_clk), .i_a(n_a[g]), .i_k(n_k[g]), .o_p(m_p[g]));
    end

    // Conv products: 32x32 signed, registered, floored.
    logic signed [31:0] r_dudx, r_dvdx, r_dpdx, r_dudy, r_dvdy, r_dpdy;
    logic signed [31:0] r_uxx, r_vxx, r_uyy, r_vyy, r_dudt, r_dvdt;
    logic signed [63:0] r_cp0, r_cp1;
    logic signed [48:0] r_convu, r_convv;
    logic signed [31:0] r_ru, r_rv, r_rp;
    logic [63:0] r_sq;
    logic [63:0] r_sum;
    logic [1:0]  r_sqi;

    fdmcr_pkg::t_in_beat w0, w1, w2;
    assign w0 = r_win[0];
    assign w1 = r_win[1];
    assign w2 = r_win[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a[i] = '0;
            n_k[i] = '0;
        end
        case (r_state)
            ST_D1: begin
                n_a[0] = 36'(w2.vel_x) - 36'(w0.vel_x);    n_k[0] = r_coef.inv_two_dx;
                n_a[1] = 36'(w2.vel_y) - 36'(w0.vel_y);    n_k[1] = r_coef.inv_two_dx;
                n_a[2] = 36'(w2.pressure) - 36'(w0.pressure); n_k[2] = r_coef.inv_two_dx;
            end
            ST_D2: begin
                n_a[0] = 36'(r_lo.vel_x) - 36'(r_up.u);    n_k[0] = r_coef.inv_two_dy;
                n_a[1] = 36'(r_lo.vel_y) - 36'(r_up.v);    n_k[1] = r_coef.inv_two_dy;
                n_a[2] = 36'(r_lo.pressure) - 36'(r_up.p); n_k[2] = r_coef.inv_two_dy;
            end
            ST_D3: begin
                n_a[0] = 36'(w2.vel_x) - 36'(w1.vel_x) - 36'(w1.vel_x) + 36'(w0.vel_x);
                n_k[0] = r_coef.inv_dx_sq;
                n_a[1] = 36'(w2.vel_y) - 36'(w1.vel_y) - 36'(w1.vel_y) + 36'(w0.vel_y);
                n_k[1] = r_coef.inv_dx_sq;
                n_a[2] = 36'(w1.vel_x) - 36'(w1.vel_x_prev);
                n_k[2] = r_coef.inv_dt;
            end
            ST_C1: begin
                n_a[0] = 36'(r_lo.vel_x) - 36'(w1.vel_x) - 36'(w1.vel_x) + 36'(r_up.u);
                n_k[0] = r_coef.inv_dy_sq;
                n_a[1] = 36'(r_lo.vel_y) - 36'(w1.vel_y) - 36'(w1.vel_y) + 36'(r_up.v);
                n_k[1] = r_coef.inv_dy_sq;
                n_a[2] = 36'(w1.vel_y) - 36'(w1.vel_y_prev);
                n_k[2] = r_coef.inv_dt;
            end
            ST_DIF: begin
                n_a[0] = 36'(r_uxx) + 36'(r_uyy); n_k[0] = r_coef.inv_reynolds;
                n_a[1] = 36'(r_vxx) + 36'(r_vyy); n_k[1] = r_coef.inv_reynolds;
            end
            default: ;
        endcase
    end

    // floor(p / 2^16) of a product
    function automatic logic signed [48:0] fl16(input logic signed [63:0] p);
        return 49'(p >>> 16);
    endfunction

    logic [63:0] n_sum_add;
    logic        n_sum_ovf;
    logic [63:0] n_sum_next;
    assign {n_sum_ovf, n_sum_add} = {1'b0, r_sum} + {1'b0, r_sq};
    // The square of step k lands in r_sq at step k+1; skip the first step.
    assign n_sum_next = (r_emit && (r_sqi != 2'd0)) ? (n_sum_ovf ? '1 : n_sum_add)
                                                    : r_sum;

    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;
    fdmcr_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
                       .i_x(n_sum_next), .o_done(sqrt_done), .o_root(sqrt_root));
    assign sqrt_start = (r_state == ST_SQ) && (r_sqi == 2'd3) && r_last;

    fdmcr_pkg::t_out_beat r_out;
    logic r_out_valid;
    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_out;

    logic signed [31:0] n_rsq;
    always_comb begin
        case (r_sqi)
            2'd0:    n_rsq = r_ru;
            2'd1:    n_rsq = r_rv;
            default: n_rsq = r_rp;
        endcase
    end
    logic [31:0] n_mag;
    assign n_mag = n_rsq[31] ? 32'(-n_rsq) : 32'(n_rsq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
            r_out_valid <= 1'b0;
            r_sqi <= '0;
            for (int i = 0; i < 3; i++) r_win[i] <= '0;
        end else begin
            // Drop the beat once taken, unless a new one loads in its place.
            if (m_out.valid && m_out.ready && !(r_state == ST_OUT && (r_emit || r_last)))
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (in_fire) begin
                    r_cur <= s_in.data;
                    r_emit <= (r_row >= RCW'(2)) && (r_col >= CW'(2));
                    r_last <= (17'(r_row) + 17'd1 >= n_rows)
                              && (17'(r_col) + 17'd1 >= n_cols);
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= r_cmem_c;
                    r_state <= ST_D1;
                end
                ST_D1: begin
                    r_lo <= (r_col != '0) ? r_cmem_cm1 : '0;
                    r_up <= (r_col != '0) ? r_umem_cm1 : '0;
                    r_state <= ST_D2;
                end
                ST_D2: begin
                    r_dudx <= fdmcr_pkg::sat32(72'(m_p[0]));
                    r_dvdx <= fdmcr_pkg::sat32(72'(m_p[1]));
                    r_dpdx <= fdmcr_pkg::sat32(72'(m_p[2]));
                    r_state <= ST_D3;
                end
                ST_D3: begin
                    r_dudy <= fdmcr_pkg::sat32(72'(m_p[0]));
                    r_dvdy <= fdmcr_pkg::sat32(72'(m_p[1]));
                    r_dpdy <= fdmcr_pkg::sat32(72'(m_p[2]));
                    r_state <= ST_C1;
                end
                ST_C1: begin
                    r_uxx  <= fdmcr_pkg::sat32(72'(m_p[0]));
                    r_vxx  <= fdmcr_pkg::sat32(72'(m_p[1]));
                    r_dudt <= fdmcr_pkg::sat32(72'(m_p[2]));
                    r_cp0 <= 64'(w1.vel_x * r_dudx);
                    r_cp1 <= 64'(w1.vel_y * r_dudy);
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    r_uyy  <= fdmcr_pkg::sat32(72'(m_p[0]));
                    r_vyy  <= fdmcr_pkg::sat32(72'(m_p[1]));
                    r_dvdt <= fdmcr_pkg::sat32(72'(m_p[2]));
                    r_convu <= fl16(r_cp0) + fl16(r_cp1);
                    r_cp0 <= 64'(w1.vel_x * r_dvdx);
                    r_cp1 <= 64'(w1.vel_y * r_dvdy);
                    r_state <= ST_DIF;
                end
                ST_DIF: begin
                    r_convv <= fl16(r_cp0) + fl16(r_cp1);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_ru <= fdmcr_pkg::sat32(72'(r_dudt) + 72'(r_convu) + 72'(r_dpdx)
                            - 72'(fdmcr_pkg::sat32(72'(m_p[0]))));
                    r_rv <= fdmcr_pkg::sat32(72'(r_dvdt) + 72'(r_convv) + 72'(r_dpdy)
                            - 72'(fdmcr_pkg::sat32(72'(m_p[1]))));
                    r_rp <= fdmcr_pkg::sat32(72'(r_dudx) + 72'(r_dvdy));
                    r_sqi <= 2'd0;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    // Accumulate the three squares, one per cycle, when emitting.
                    r_sum <= n_sum_next;
                    if (r_sqi != 2'd3) begin
                        r_sqi <= r_sqi + 2'd1;
                    end else if (r_last) begin
                        r_state <= ST_SQRT;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_SQRT: if (sqrt_done) begin
                    r_state <= ST_OUT;
                end
                ST_OUT: if (!r_out_valid || m_out.ready) begin
                    // Hold until the output register frees up.
                    if (r_emit || r_last) begin
                        r_out_valid <= 1'b1;
                        r_out.cell_row <= r_emit ? 12'(r_row - RCW'(1)) : '0;
                        r_out.cell_col <= r_emit ? 10'(r_col - CW'(1)) : '0;
                        r_out.resid_mom_x <= r_emit ? r_ru : '0;
                        r_out.resid_mom_y <= r_emit ? r_rv : '0;
                        r_out.resid_cont  <= r_emit ? r_rp : '0;
                        r_out.norm_value  <= r_last ? sqrt_root : '0;
                        r_out.is_norm     <= r_last;
                    end
                    if (r_last) begin
                        r_sum <= '0;
                        r_col <= '0;
                        r_row <= '0;
                    end else if (17'(r_col) + 17'd1 >= n_cols) begin
                        r_col <= '0;
                        r_row <= r_row + RCW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Square of the selected residual, registered for the accumulator.
    always_ff @(posedge i_clk) begin
        r_sq <= 64'(n_mag) * 64'(n_mag);
    end
endmodule

[tb/sv/fdmcr_checker.sv]
// Residual stencil checker: predicts cell residuals and norms, compares result beats.
`timescale 1ns / 100ps
module fdmcr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  fdmcr_pkg::t_in_beat  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  fdmcr_pkg::t_out_beat i_out_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int unsigned COLS_MAX = 1024;
    localparam int unsigned ROWS_MAX = 4096;

    fdmcr_pkg::t_flow     upper_line  [COLS_MAX];
    fdmcr_pkg::t_in_beat  center_line [COLS_MAX];
    fdmcr_pkg::t_in_beat  window      [3];
    logic [63:0]          square_acc;
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic [10:0]          reg_cols;
    logic [12:0]          reg_rows;
    fdmcr_pkg::t_coef     coef;
    fdmcr_pkg::t_out_beat pending_residuals[$];
    int                   mismatches;

    assign o_errors = mismatches;

    // floor(a * k / 2^16), exact
    function automatic logic signed [63:0] scale_q16(input logic signed [63:0] a,
                                                     input logic [31:0] k);
        logic signed [95:0] aw;
        logic signed [95:0] kw;
        logic signed [95:0] p;
        aw = a;
        kw = $signed({64'd0, k});
        p  = aw * kw;
        return p >>> 16;
    endfunction

    function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000)
            return -64'sh8000_0000;
        return x;
    endfunction

    function automatic logic signed [63:0] prod_q16(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic accumulate_square(input logic signed [63:0] r);
        logic [63:0] m;
        logic [64:0] s;
        m = (r < 0) ? -r : r;
        s = {1'b0, square_acc} + {1'b0, m * m};
        square_acc = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endtask

    task automatic predict_point(input fdmcr_pkg::t_in_beat cur);
        int unsigned cols, rows, c, r;
        fdmcr_pkg::t_flow up;
        fdmcr_pkg::t_in_beat lo;
        logic signed [63:0] u0, u1, u2, v0, v1, v2, p0, p2, uo, vo;
        logic signed [63:0] lu, lv, lp, au, av, ap;
        logic signed [63:0] dudx, dvdx, dpdx, dudy, dvdy, dpdy;
        logic signed [63:0] uxx, vxx, uyy, vyy, dudt, dvdt, difu, difv;
        logic signed [63:0] ru, rv, rp;
        fdmcr_pkg::t_out_beat res;
        bit emit, last;
        cols = reg_cols;
        rows = reg_rows;
        if (cols < 3) cols = 3;
        if (cols > COLS_MAX) cols = COLS_MAX;
        if (rows < 3) rows = 3;
        if (rows > ROWS_MAX) rows = ROWS_MAX;
        c = col_pos;
        r = row_pos;

        window[0] = window[1];
        window[1] = window[2];
        window[2] = center_line[c];
        up = '0;
        lo = '0;
        if (c >= 1) begin
            up = upper_line[c-1];
            lo = center_line[c-1];
            upper_line[c-1] = '{window[1].vel_x, window[1].vel_y, window[1].pressure};
        end
        center_line[c] = cur;

        emit = (r >= 2 && c >= 2);
        last = (r + 1 >= rows && c + 1 >= cols);
        res  = '0;

        if (emit) begin
            u0 = window[0].vel_x;  u1 = window[1].vel_x;  u2 = window[2].vel_x;
            v0 = window[0].vel_y;  v1 = window[1].vel_y;  v2 = window[2].vel_y;
            p0 = window[0].pressure;  p2 = window[2].pressure;
            uo = window[1].vel_x_prev;  vo = window[1].vel_y_prev;
            lu = lo.vel_x;  lv = lo.vel_y;  lp = lo.pressure;
            au = up.u;  av = up.v;  ap = up.p;

            dudx = clamp_s32(scale_q16(u2 - u0, coef.inv_two_dx));
            dvdx = clamp_s32(scale_q16(v2 - v0, coef.inv_two_dx));
            dpdx = clamp_s32(scale_q16(p2 - p0, coef.inv_two_dx));
            dudy = clamp_s32(scale_q16(lu - au, coef.inv_two_dy));
            dvdy = clamp_s32(scale_q16(lv - av, coef.inv_two_dy));
            dpdy = clamp_s32(scale_q16(lp - ap, coef.inv_two_dy));
            uxx  = clamp_s32(scale_q16(u2 - 2 * u1 + u0, coef.inv_dx_sq));
            vxx  = clamp_s32(scale_q16(v2 - 2 * v1 + v0, coef.inv_dx_sq));
            uyy  = clamp_s32(scale_q16(lu - 2 * u1 + au, coef.inv_dy_sq));
            vyy  = clamp_s32(scale_q16(lv - 2 * v1 + av, coef.inv_dy_sq));
            dudt = clamp_s32(scale_q16(u1 - uo, coef.inv_dt));
            dvdt = clamp_s32(scale_q16(v1 - vo, coef.inv_dt));
            difu = clamp_s32(scale_q16(uxx + uyy, coef.inv_reynolds));
            difv = clamp_s32(scale_q16(vxx + vyy, coef.inv_reynolds));
            ru = clamp_s32(dudt + prod_q16(u1, dudx) + prod_q16(v1, dudy) + dpdx - difu);
            rv = clamp_s32(dvdt + prod_q16(u1, dvdx) + prod_q16(v1, dvdy) + dpdy - difv);
            rp = clamp_s32(dudx + dvdy);

            accumulate_square(ru);
            accumulate_square(rv);
            accumulate_square(rp);

            res.cell_row    = 12'(r - 1);
            res.cell_col    = 10'(c - 1);
            res.resid_mom_x = ru[31:0];
            res.resid_mom_y = rv[31:0];
            res.resid_cont  = rp[31:0];
        end

        if (last) begin
            res.norm_value = root64(square_acc);
            res.is_norm    = 1'b1;
            square_acc = '0;
            col_pos = 0;
            row_pos = 0;
        end else if (c + 1 >= cols) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
        end
        if (emit || last)
            pending_residuals.push_back(res);
    endtask

    always @(posedge i_clk) begin
        fdmcr_pkg::t_out_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < COLS_MAX; i++) begin
                upper_line[i]  = '0;
                center_line[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                window[i] = '0;
            square_acc = '0;
            col_pos    = 0;
            row_pos    = 0;
            reg_cols   = 11'd64;
            reg_rows   = 13'd64;
            coef       = '{32'd32768, 32'd32768, 32'd65536, 32'd65536, 32'd65536, 32'd65536};
            pending_residuals.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fdmcr_pkg::CFG_GRID_COLS:    reg_cols          = i_cfg_data[10:0];
                    fdmcr_pkg::CFG_GRID_ROWS:    reg_rows          = i_cfg_data[12:0];
                    fdmcr_pkg::CFG_INV_TWO_DX:   coef.inv_two_dx   = i_cfg_data;
                    fdmcr_pkg::CFG_INV_TWO_DY:   coef.inv_two_dy   = i_cfg_data;
                    fdmcr_pkg::CFG_INV_DX_SQ:    coef.inv_dx_sq    = i_cfg_data;
                    fdmcr_pkg::CFG_INV_DY_SQ:    coef.inv_dy_sq    = i_cfg_data;
                    fdmcr_pkg::CFG_INV_DT:       coef.inv_dt       = i_cfg_data;
                    fdmcr_pkg::CFG_INV_REYNOLDS: coef.inv_reynolds = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_residuals.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat row %0d col %0d norm %0d",
                                 i_out_data.cell_row, i_out_data.cell_col, i_out_data.is_norm);
                end else begin
                    want = pending_residuals.pop_front();
                    if (i_out_data.cell_row !== want.cell_row
                        || i_out_data.cell_col !== want.cell_col
                        || i_out_data.resid_mom_x !== want.resid_mom_x
                        || i_out_data.resid_mom_y !== want.resid_mom_y
                        || i_out_data.resid_cont !== want.resid_cont
                        || i_out_data.norm_value !== want.norm_value
                        || i_out_data.is_norm !== want.is_norm) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result mismatch\n  exp row %0d col %0d mx %h my %h",
                                      " ct %h norm %h last %b\n  got row %0d col %0d mx %h my %h",
                                      " ct %h norm %h last %b"},
                                     want.cell_row, want.cell_col, want.resid_mom_x,
                                     want.resid_mom_y, want.resid_cont, want.norm_value,
                                     want.is_norm, i_out_data.cell_row, i_out_data.cell_col,
                                     i_out_data.resid_mom_x, i_out_data.resid_mom_y,
                                     i_out_data.resid_cont, i_out_data.norm_value,
                                     i_out_data.is_norm);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_point(i_in_data);
        end
        o_pending = pending_residuals.size();
    end

endmodule

[tb/sv/testbench.sv]
// Top of the residual stencil testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_cnt;
    int          random_points;
    int          grid_no;
    logic [31:0] cfg_val [fdmcr_pkg::NUM_CFG];

    fdmcr_stream_if #(.T(fdmcr_pkg::t_in_beat))  in_if ();
    fdmcr_stream_if #(.T(fdmcr_pkg::t_out_beat)) out_if ();

    fd_momentum_continuity_residual DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_if),
        .m_out      (out_if)
    );

    fdmcr_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (in_if.valid),
        .i_in_ready  (in_if.ready),
        .i_in_data   (in_if.data),
        .i_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_out_data  (out_if.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("fd_momentum_continuity_residual test failed");
            $finish;
        end
    end

    // Receiver: pick a new stall pattern whenever stall_cnt is a multiple of 256.
    always @(negedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 256 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= ($urandom_range(0, 3) != 0);
            default: out_if.ready <= (stall_cnt % 7 >= 3);
        endcase
    end

    function automatic logic [31:0] field_value(input int mode);
        logic [31:0] pick [5];
        pick = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
        case (mode)
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            2:       return pick[$urandom_range(0, 4)];
            default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
        endcase
    endfunction

    function automatic fdmcr_pkg::t_in_beat make_point(input int mode);
        fdmcr_pkg::t_in_beat p;
        int m;
        m = mode;
        if (mode > 3)
            m = $urandom_range(0, 3);
        p.vel_x      = field_value(m);
        p.vel_y      = field_value(m);
        p.pressure   = field_value(m);
        p.vel_x_prev = field_value(m);
        p.vel_y_prev = field_value(m);
        return p;
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 32'h3_FFFF);
            default: return 32'h8000 + $urandom_range(0, 32'h2_0000);
        endcase
    endfunction

    task automatic send_point(input fdmcr_pkg::t_in_beat d);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.data  <= d;
        do
            @(posedge i_clk);
        while (!in_if.ready);
    endtask

    // Hold off until every expected beat has come, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_grid(input int mode, input int mid_drain);
        int cols, rows, total;
        drain();
        for (int i = 0; i < fdmcr_pkg::NUM_CFG; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= cfg_val[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cols = cfg_val[fdmcr_pkg::CFG_GRID_COLS] & 32'h7FF;
        rows = cfg_val[fdmcr_pkg::CFG_GRID_ROWS] & 32'h1FFF;
        cols = (cols < 3) ? 3 : (cols > 1024) ? 1024 : cols;
        rows = (rows < 3) ? 3 : (rows > 4096) ? 4096 : rows;
        total = cols * rows;
        for (int i = 0; i < total; i++) begin
            if (mid_drain && i == total / 2)
                drain();
            send_point(make_point(mode));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = fdmcr_pkg::CFG_GRID_COLS;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cycles       = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_cnt    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Smallest grid, default coefficients, extreme samples.
        cfg_val = '{32'd3, 32'd3, 32'd32768, 32'd32768, 32'd65536, 32'd65536,
                    32'd65536, 32'd65536};
        run_grid(2, 0);
        // Undersized registers clamp to 3x3; largest coefficients saturate.
        cfg_val = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        run_grid(2, 0);
        cfg_val = '{32'd4, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        run_grid(0, 0);

        random_points = 0;
        grid_no = 0;
        while (random_points < 1420) begin
            cfg_val[fdmcr_pkg::CFG_GRID_COLS] = ($urandom_range(0, 9) == 0)
                                                ? $urandom_range(0, 2)
                                                : $urandom_range(3, 12);
            cfg_val[fdmcr_pkg::CFG_GRID_ROWS] = ($urandom_range(0, 9) == 0)
                                                ? $urandom_range(0, 2)
                                                : $urandom_range(3, 9);
            for (int i = fdmcr_pkg::CFG_INV_TWO_DX; i < fdmcr_pkg::NUM_CFG; i++)
                cfg_val[i] = pick_coef();
            run_grid($urandom_range(0, 4), grid_no == 1);
            random_points += ((cfg_val[fdmcr_pkg::CFG_GRID_COLS] < 3)
                              ? 3 : cfg_val[fdmcr_pkg::CFG_GRID_COLS])
                           * ((cfg_val[fdmcr_pkg::CFG_GRID_ROWS] < 3)
                              ? 3 : cfg_val[fdmcr_pkg::CFG_GRID_ROWS]);
            grid_no++;
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("fd_momentum_continuity_residual test passed");
        end else begin
            $display("fd_momentum_continuity_residual test failed");
        end
        $finish;
    end

endmodule
